@@ hw/rtl/tpp_pkg.sv @@
`timescale 1ns / 1ps

package tpp_pkg;

    localparam int NSLOTS = 4;
    localparam int OFF_W  = 11;
    localparam int LEN_W  = 8;
    localparam int CODE_W = 8;
    localparam int IDX_W  = 2;

    localparam logic [1:0] PH_TYPE  = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERRUN  = 2'd1;
    localparam logic [1:0] ST_TRAILING = 2'd2;
    localparam logic [1:0] ST_OVERCAP  = 2'd3;

    localparam logic [IDX_W-1:0] REG_NONCE    = 2'd0;
    localparam logic [IDX_W-1:0] REG_PASSWORD = 2'd1;
    localparam logic [IDX_W-1:0] REG_COMMAND  = 2'd2;
    localparam logic [IDX_W-1:0] REG_OUTPUT   = 2'd3;

    typedef logic [NSLOTS-1:0][CODE_W-1:0] t_codes;

    typedef struct packed {
        logic [NSLOTS-1:0][LEN_W-1:0] length;
        logic [NSLOTS-1:0][OFF_W-1:0] offset;
        logic [NSLOTS-1:0]            found;
        logic [1:0]                   status;
    } t_result;

endpackage

@@ hw/rtl/tlv_payload_parser.sv @@
`timescale 1ns / 1ps

// Type/length/value payload parser. Takes one payload byte per cycle on the
// slave stream while tready is high and updates its parse state as each byte
// is accepted; the state update is a step of the phase counter and slot
// capture logic. A beat with tlast, or with tuser (empty packet) set, closes
// the packet and produces one result beat, registered in the output buffer
// before it reaches the master stream. Results sit in a two-entry output
// buffer: tready drops only while two results wait to be taken. The user
// must write capture type codes through the config port only while idle;
// the block does not enforce this. No clearing pass is needed after reset.
module tlv_payload_parser
    import tpp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,

    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,  // [7:0] payload_byte
    input  logic             s_axis_tlast,
    input  logic             s_axis_tuser,  // [0] empty_packet

    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [1:0] status, [5:2] found_mask, [16:6] nonce_offset, [24:17] nonce_length,
    // [35:25] password_offset, [43:36] password_length, [54:44] command_offset,
    // [62:55] command_length, [73:63] output_offset, [81:74] output_length,
    // [87:82] zero
    output logic [87:0]      m_axis_tdata,

    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [7:0]       i_cfg_data
);

    t_codes  codes;
    t_result result;
    t_result out_res;
    logic    push;
    logic    space;
    logic    accept;

    assign s_axis_tready = space;
    assign accept        = s_axis_tvalid && space;

    tpp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_ready (o_cfg_ready),
        .o_codes (codes)
    );

    tpp_parse #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_empty  (s_axis_tuser),
        .i_codes  (codes),
        .o_push   (push),
        .o_result (result)
    );

    tpp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_space (space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_res)
    );

    assign m_axis_tdata = {6'b0,
                           out_res.length[3], out_res.offset[3],
                           out_res.length[2], out_res.offset[2],
                           out_res.length[1], out_res.offset[1],
                           out_res.length[0], out_res.offset[0],
                           out_res.found, out_res.status};

endmodule

@@ hw/rtl/tpp_cfg.sv @@
`timescale 1ns / 1ps

module tpp_cfg
    import tpp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [IDX_W-1:0] i_index,
    input  logic [7:0]       i_data,
    output logic             o_ready,
    output t_codes           o_codes
);

    t_codes r_codes;

    assign o_ready = 1'b1;
    assign o_codes = r_codes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes[REG_NONCE]    <= 8'd1;
            r_codes[REG_PASSWORD] <= 8'd2;
            r_codes[REG_COMMAND]  <= 8'd3;
            r_codes[REG_OUTPUT]   <= 8'd4;
        end else if (i_valid) begin
            r_codes[i_index] <= i_data;
        end
    end

endmodule

@@ hw/rtl/tpp_parse.sv @@
`timescale 1ns / 1ps

module tpp_parse
    import tpp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 2048
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic [7:0] i_byte,
    input  logic    i_last,
    input  logic    i_empty,
    input  t_codes  i_codes,
    output logic    o_push,
    output t_result o_result
);

    localparam int POS_W = $clog2(MAX_PAYLOAD + 1);
    localparam int CW    = (POS_W > OFF_W) ? POS_W : OFF_W;

    logic [1:0]                   r_phase, n_phase;
    logic [POS_W-1:0]             r_pos, n_pos;
    logic [CODE_W-1:0]            r_type, n_type;
    logic [LEN_W-1:0]             r_left, n_left;
    logic [LEN_W-1:0]             r_plen, n_plen;
    logic [OFF_W-1:0]             r_vstart, n_vstart;
    logic [NSLOTS-1:0][OFF_W-1:0] r_off, n_off;
    logic [NSLOTS-1:0][LEN_W-1:0] r_len, n_len;
    logic [NSLOTS-1:0]            r_found, n_found;
    logic                         r_over, n_over;

    logic [CW-1:0]    pos_inc;
    logic             commit;
    logic [OFF_W-1:0] commit_off;
    logic             close;

    assign pos_inc = CW'(r_pos) + CW'(1);
    assign close   = i_empty || i_last;

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_type     = r_type;
        n_left     = r_left;
        n_plen     = r_plen;
        n_vstart   = r_vstart;
        n_off      = r_off;
        n_len      = r_len;
        n_found    = r_found;
        n_over     = r_over;
        commit     = 1'b0;
        commit_off = r_vstart;

        if (!i_empty) begin
            if (r_pos >= POS_W'(MAX_PAYLOAD)) begin
                n_over = 1'b1;
            end else begin
                n_pos = pos_inc[POS_W-1:0];
                unique case (r_phase)
                    PH_LEN: begin
                        n_plen   = i_byte;
                        n_vstart = pos_inc[OFF_W-1:0];
                        if (i_byte == '0) begin
                            commit     = 1'b1;
                            commit_off = pos_inc[OFF_W-1:0];
                            n_phase    = PH_TYPE;
                        end else begin
                            n_left  = i_byte;
                            n_phase = PH_VALUE;
                        end
                    end
                    PH_VALUE: begin
                        n_left = r_left - LEN_W'(1);
                        if (r_left == LEN_W'(1)) begin
                            commit  = 1'b1;
                            n_phase = PH_TYPE;
                        end
                    end
                    default: begin
                        // unused phase code behaves as expect-type
                        n_type  = i_byte;
                        n_phase = PH_LEN;
                    end
                endcase
            end
        end

        // lowest-numbered slot wins on duplicate codes
        if (commit) begin
            priority if (i_codes[0] == r_type) begin
                n_off[0] = commit_off; n_len[0] = n_plen; n_found[0] = 1'b1;
            end else if (i_codes[1] == r_type) begin
                n_off[1] = commit_off; n_len[1] = n_plen; n_found[1] = 1'b1;
            end else if (i_codes[2] == r_type) begin
                n_off[2] = commit_off; n_len[2] = n_plen; n_found[2] = 1'b1;
            end else if (i_codes[3] == r_type) begin
                n_off[3] = commit_off; n_len[3] = n_plen; n_found[3] = 1'b1;
            end
        end
    end

    always_comb begin
        o_push   = i_accept && close;
        o_result = '0;
        if (n_over) begin
            o_result.status = ST_OVERCAP;
        end else begin
            unique case (n_phase)
                PH_VALUE: o_result.status = ST_OVERRUN;
                PH_LEN:   o_result.status = ST_TRAILING;
                default:  o_result.status = ST_OK;
            endcase
            o_result.found  = n_found;
            o_result.offset = n_off;
            o_result.length = n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && close)) begin
            r_phase  <= PH_TYPE;
            r_pos    <= '0;
            r_type   <= '0;
            r_left   <= '0;
            r_plen   <= '0;
            r_vstart <= '0;
            r_off    <= '0;
            r_len    <= '0;
            r_found  <= '0;
            r_over   <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_type   <= n_type;
            r_left   <= n_left;
            r_plen   <= n_plen;
            r_vstart <= n_vstart;
            r_off    <= n_off;
            r_len    <= n_len;
            r_found  <= n_found;
            r_over   <= n_over;
        end
    end

endmodule

@@ hw/rtl/tpp_out_buf.sv @@
`timescale 1ns / 1ps

module tpp_out_buf
    import tpp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !i_ready) begin
            // hold the waiting beat, park a new one behind it
            if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= i_push;
        end else begin
            r_out_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !i_ready) begin
            if (i_push) begin
                r_skid <= i_data;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
            if (i_push) begin
                r_skid <= i_data;
            end
        end else if (i_push) begin
            r_out <= i_data;
        end
    end

endmodule
